/* rtl/emst_pkg.sv */
// emst_pkg: shared constants for the euclidean spanning tree block
// no dependencies
`timescale 1ns / 1ps
package emst_pkg;
    localparam int MaxPoints = 64;
    localparam int IdxW = $clog2(MaxPoints);
    localparam int CntW = $clog2(MaxPoints + 1);
    localparam int CoordW = 24;
    localparam int DiffW = 25;
    localparam int SqW = 51;
    localparam int RootW = 26;
endpackage

/* rtl/emst_if.sv */
// emst_if: valid/ready channel carrying a payload of generic type
// depends on nothing
`timescale 1ns / 1ps
interface emst_if #(parameter type t_payload = logic) (input logic i_clk);
    logic     valid;
    logic     ready;
    t_payload data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/emst_sqrt.sv */
// emst_sqrt: bit-serial integer square root, one result bit a cycle
// depends on emst_pkg
`timescale 1ns / 1ps
module emst_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [emst_pkg::SqW-1:0]   i_value,
    output logic                       o_done,
    output logic [emst_pkg::RootW-1:0] o_root
);
    import emst_pkg::*;
    localparam int RemW = SqW + 3;
    logic [RemW-1:0]   r_rem;
    logic [SqW:0]      r_val;
    logic [RootW-1:0]  r_root;
    logic [4:0]        r_cnt;
    logic              r_busy;
    logic [RemW-1:0]   w_trial;
    logic [RemW-1:0]   w_shift;
    always_comb begin
        w_shift = {r_rem[RemW-3:0], r_val[SqW:SqW-1]};
        w_trial = {{(RemW-RootW-2){1'b0}}, r_root, 2'b01};
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= '0;
                r_root <= '0;
                r_val  <= {1'b0, i_value};
                r_cnt  <= 5'(RootW - 1);
            end else if (r_busy) begin
                r_val <= {r_val[SqW-2:0], 2'b00};
                if (w_shift >= w_trial) begin
                    r_rem  <= w_shift - w_trial;
                    r_root <= {r_root[RootW-2:0], 1'b1};
                end else begin
                    r_rem  <= w_shift;
                    r_root <= {r_root[RootW-2:0], 1'b0};
                end
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 5'd1;
                end
            end
        end
    end
    assign o_root = r_root;
endmodule

/* rtl/euclidean_mst_length.sv */
// euclidean_mst_length: prim spanning tree over stored points, one shared
// distance unit and a serial square root; uses emst_pkg, emst_if, emst_sqrt
// points are taken back to back while loading; after the last point the tree is
// built with the shared distance unit and the serial square root for each edge;
// not ready meanwhile
// reset: synchronous active low, clears count, flags and sequencer
`timescale 1ns / 1ps
module euclidean_mst_length (
    input  logic i_clk,
    input  logic i_rst_n,
    emst_if.sink   i_pt,
    emst_if.source o_res
);
    import emst_pkg::*;
    typedef enum logic [3:0] {
        S_LOAD, S_INIT, S_SCAN, S_PICK, S_SQRT, S_WAITSQ, S_UPD, S_OUT
    } t_state;
    t_state r_state;
    logic [CoordW-1:0] r_mx [MaxPoints];
    logic [CoordW-1:0] r_my [MaxPoints];
    logic [SqW-1:0]    r_best [MaxPoints];
    logic [MaxPoints-1:0] r_joined;
    logic [CntW-1:0]   r_count;
    logic              r_drop;
    logic [31:0]       r_sum;
    logic [IdxW-1:0]   r_pick;
    logic [CntW-1:0]   r_i, r_left;
    logic              r_found;
    logic [SqW-1:0]    r_pbest;
    logic [CoordW-1:0] r_ax, r_ay, r_bx, r_by;
    logic [SqW-1:0]    r_d, r_cur;
    logic [1:0]        r_ph;
    logic              r_sq_start;
    logic              w_sq_done;
    logic [RootW-1:0]  w_root;
    logic [DiffW-1:0]  w_dx, w_dy, w_ax, w_ay;
    logic [SqW-1:0]    w_d;
    logic [32:0]       w_add;
    logic [IdxW-1:0]   w_i;
    assign w_i  = r_i[IdxW-1:0];
    assign w_dx = DiffW'($signed(r_ax)) - DiffW'($signed(r_bx));
    assign w_dy = DiffW'($signed(r_ay)) - DiffW'($signed(r_by));
    assign w_ax = w_dx[DiffW-1] ? -w_dx : w_dx;
    assign w_ay = w_dy[DiffW-1] ? -w_dy : w_dy;
    assign w_d  = SqW'(w_ax * w_ax) + SqW'(w_ay * w_ay);
    assign w_add = {1'b0, r_sum} + 33'(w_root);
    emst_sqrt u_sqrt (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_sq_start),
        .i_value(r_pbest), .o_done(w_sq_done), .o_root(w_root));
    assign i_pt.ready = (r_state == S_LOAD);
    always_ff @(posedge i_clk) begin
        if (i_pt.valid && i_pt.ready && r_count < CntW'(MaxPoints)) begin
            r_mx[r_count[IdxW-1:0]] <= i_pt.data.point_x;
            r_my[r_count[IdxW-1:0]] <= i_pt.data.point_y;
        end
        r_bx <= r_mx[w_i];
        r_by <= r_my[w_i];
        r_cur <= r_best[w_i];
        r_ax <= r_mx[r_pick];
        r_ay <= r_my[r_pick];
        r_d  <= w_d;
        if (r_state == S_INIT && r_ph == 2'd3) r_best[w_i] <= r_d;
        if (r_state == S_UPD && r_ph == 2'd3 && !r_joined[w_i] && r_d < r_cur)
            r_best[w_i] <= r_d;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_drop <= 1'b0;
            o_res.valid <= 1'b0;
            r_sq_start <= 1'b0;
            r_ph <= '0;
        end else begin
            r_sq_start <= 1'b0;
            case (r_state)
                S_LOAD: begin
                    if (i_pt.valid) begin
                        if (r_count < CntW'(MaxPoints)) r_count <= r_count + 1'b1;
                        else r_drop <= 1'b1;
                        if (i_pt.data.last_point) begin
                            r_state <= S_INIT;
                            r_sum <= '0;
                            r_pick <= '0;
                            r_i <= '0;
                            r_ph <= '0;
                            r_joined <= '0;
                        end
                    end
                end
                S_INIT: begin
                    r_ph <= r_ph + 2'd1;
                    if (r_ph == 2'd3) begin
                        if (r_i + 1'b1 >= r_count) begin
                            r_joined[0] <= 1'b1;
                            r_left <= r_count - 1'b1;
                            r_state <= (r_count < CntW'(2)) ? S_OUT : S_SCAN;
                            r_i <= '0;
                            r_found <= 1'b0;
                            if (r_count < CntW'(2)) o_res.valid <= 1'b1;
                        end else r_i <= r_i + 1'b1;
                    end
                end
                S_SCAN: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else begin
                        r_ph <= '0;
                        if (!r_joined[w_i] && (!r_found || r_cur < r_pbest)) begin
                            r_found <= 1'b1;
                            r_pick <= w_i;
                            r_pbest <= r_cur;
                        end
                        if (r_i + 1'b1 >= r_count) r_state <= S_PICK;
                        else r_i <= r_i + 1'b1;
                    end
                end
                S_PICK: begin
                    r_joined[r_pick] <= 1'b1;
                    r_sq_start <= 1'b1;
                    r_state <= S_WAITSQ;
                end
                S_WAITSQ: begin
                    if (w_sq_done) begin
                        r_sum <= w_add[32] ? 32'hFFFF_FFFF : w_add[31:0];
                        r_i <= '0;
                        r_ph <= '0;
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_ph <= r_ph + 2'd1;
                    if (r_ph == 2'd3) begin
                        if (r_i + 1'b1 >= r_count) begin
                            r_i <= '0;
                            r_found <= 1'b0;
                            r_left <= r_left - 1'b1;
                            if (r_left == CntW'(1)) begin
                                r_state <= S_OUT;
                                o_res.valid <= 1'b1;
                            end else r_state <= S_SCAN;
                        end else r_i <= r_i + 1'b1;
                    end
                end
                S_OUT: begin
                    if (o_res.ready) begin
                        o_res.valid <= 1'b0;
                        r_count <= '0;
                        r_drop <= 1'b0;
                        r_state <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end
    assign o_res.data.total_length = (r_count < CntW'(2)) ? 32'd0 : r_sum;
    assign o_res.data.points_used = 7'(r_count);
    assign o_res.data.overflow = r_drop;

    a_ready_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !i_pt.ready) else $error("input open during result");
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(MaxPoints)) else $error("count beyond capacity");
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |=> o_res.valid) else $error("result dropped");
endmodule

/* tb/sv/euclidean_mst_length_tb.sv */
// euclidean_mst_length_tb: drives point sets into the spanning tree block and checks
// each result against an own prim predictor; uses emst_pkg, emst_if, euclidean_mst_length
`timescale 1ns / 1ps
module euclidean_mst_length_tb;
    import emst_pkg::*;

    typedef struct packed {
        logic signed [CoordW-1:0] point_x;
        logic signed [CoordW-1:0] point_y;
        logic                     last_point;
    } t_point;

    typedef struct packed {
        logic [31:0] total_length;
        logic [6:0]  points_used;
        logic        overflow;
    } t_tree_res;

    class t_tree_scoreboard;
        longint      set_x[$];
        longint      set_y[$];
        bit          set_dropped;
        t_tree_res   pending[$];
        int          mismatches;

        function longint unsigned root_floor(longint unsigned n);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function longint unsigned span_sq(int a, int c);
            longint dx;
            longint dy;
            dx = set_x[a] - set_x[c];
            dy = set_y[a] - set_y[c];
            return dx * dx + dy * dy;
        endfunction

        function logic [31:0] tree_length();
            longint unsigned best[MaxPoints];
            bit              joined[MaxPoints];
            longint unsigned acc;
            longint unsigned d;
            int              n;
            int              pick;
            bit              found;
            n = set_x.size();
            acc = 0;
            if (n < 2) return 32'd0;
            for (int i = 0; i < n; i++) begin
                joined[i] = 0;
                best[i] = span_sq(0, i);
            end
            joined[0] = 1;
            for (int k = 1; k < n; k++) begin
                pick = 0;
                found = 0;
                for (int i = 0; i < n; i++)
                    if (!joined[i] && (!found || best[i] < best[pick])) begin
                        pick = i;
                        found = 1;
                    end
                joined[pick] = 1;
                acc = acc + root_floor(best[pick]);
                if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
                for (int i = 0; i < n; i++)
                    if (!joined[i]) begin
                        d = span_sq(pick, i);
                        if (d < best[i]) best[i] = d;
                    end
            end
            return acc[31:0];
        endfunction

        function void note_point(t_point p);
            t_tree_res e;
            if (set_x.size() < MaxPoints) begin
                set_x.push_back(longint'(p.point_x));
                set_y.push_back(longint'(p.point_y));
            end else begin
                set_dropped = 1;
            end
            if (p.last_point) begin
                e.total_length = tree_length();
                e.points_used = 7'(set_x.size());
                e.overflow = set_dropped;
                pending.push_back(e);
                set_x.delete();
                set_y.delete();
                set_dropped = 0;
            end
        endfunction

        function void check_result(t_tree_res r);
            t_tree_res e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: len %0d used %0d ovf %0d",
                             r.total_length, r.points_used, r.overflow);
                return;
            end
            e = pending.pop_front();
            if (r !== e) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp len %0d used %0d ovf %0d, ",
                              "got len %0d used %0d ovf %0d"},
                             e.total_length, e.points_used, e.overflow,
                             r.total_length, r.points_used, r.overflow);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    emst_if #(.t_payload(t_point))    pt_ch (i_clk);
    emst_if #(.t_payload(t_tree_res)) res_ch (i_clk);

    euclidean_mst_length i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pt   (pt_ch.sink),
        .o_res  (res_ch.source)
    );

    t_tree_scoreboard sb;
    int  idle_cycles;
    int  results_seen;
    bit  hold_done;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    function automatic logic signed [CoordW-1:0] pick_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return CoordW'($urandom);
        if (r < 8) return CoordW'($signed($urandom_range(0, 2000)) - 1000);
        if (r == 8) return {1'b1, {(CoordW-1){1'b0}}};
        return {1'b0, {(CoordW-1){1'b1}}};
    endfunction

    task automatic send_point(logic signed [CoordW-1:0] x, logic signed [CoordW-1:0] y,
                              logic last);
        t_point p;
        int     g;
        p.point_x = x;
        p.point_y = y;
        p.last_point = last;
        pt_ch.valid <= 1'b1;
        pt_ch.data <= p;
        do @(posedge i_clk); while (!(pt_ch.valid && pt_ch.ready));
        sb.note_point(p);
        g = pick_gap();
        if (g > 0) begin
            pt_ch.valid <= 1'b0;
            pt_ch.data <= t_point'($urandom);
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic send_set(int n);
        for (int i = 0; i < n; i++)
            send_point(pick_coord(), pick_coord(), i == n - 1);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            sb.check_result(res_ch.data);
            results_seen++;
        end
        if ((pt_ch.valid && pt_ch.ready) || (res_ch.valid && res_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 200000) begin
            $display("FAIL");
            $finish;
        end
    end

    // sink side: random back-pressure, one long hold-off
    initial begin
        int g;
        res_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!hold_done && results_seen >= 4) begin
                hold_done = 1;
                res_ch.ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
            end
            g = pick_gap();
            if (g > 0) begin
                res_ch.ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    initial begin
        int sent;
        int n;
        sb = new();
        idle_cycles = 0;
        results_seen = 0;
        hold_done = 0;
        i_rst_n <= 1'b0;
        pt_ch.valid <= 1'b0;
        pt_ch.data <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single point, two opposite-corner pairs, coincident points, small four-point set
        send_point(24'sd0, 24'sd0, 1'b1);
        send_point({1'b1, 23'd0}, {1'b1, 23'd0}, 1'b0);
        send_point({1'b0, {23{1'b1}}}, {1'b0, {23{1'b1}}}, 1'b1);
        send_point({1'b1, 23'd0}, {1'b0, {23{1'b1}}}, 1'b0);
        send_point({1'b0, {23{1'b1}}}, {1'b1, 23'd0}, 1'b1);
        send_point(24'sd5, 24'sd5, 1'b0);
        send_point(24'sd5, 24'sd5, 1'b1);
        send_point(24'sd0, 24'sd0, 1'b0);
        send_point(24'sd3, 24'sd0, 1'b0);
        send_point(24'sd0, 24'sd4, 1'b0);
        send_point(-24'sd1, -24'sd1, 1'b1);
        // full store, then store overflow with last point dropped
        send_set(MaxPoints);
        send_set(MaxPoints + 3);

        sent = 0;
        while (sent < 1500) begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(MaxPoints - 2, MaxPoints + 4)
                                              : $urandom_range(1, 8);
            send_set(n);
            sent += n;
        end
        pt_ch.valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

/* filelist.f */
rtl/emst_pkg.sv
rtl/emst_if.sv
rtl/emst_sqrt.sv
rtl/euclidean_mst_length.sv
tb/sv/euclidean_mst_length_tb.sv
